### src/fwac_pkg.sv
// -----------------------------------------------------------------------------
// fwac_pkg: shared types and constants
// Word layouts, result codes, sequencer states and shared-unit request type
// for the weighted admission controller.
// -----------------------------------------------------------------------------
package fwac_pkg;

	// field widths
	localparam int UNITS_W = 32;
	localparam int TAG_W   = 8;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 3;
	localparam int WAIT_W  = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// waiter queue depth; waiting_count is sized to hold it
	localparam int QUEUE_DEPTH = 16;

	// function codes of an input word
	localparam logic FUNC_ACCEPT  = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
	localparam logic [STAT_W-1:0] STAT_QUEUED       = 3'd1;
	localparam logic [STAT_W-1:0] STAT_OVER_LIMIT   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_OVER_RELEASE = 3'd3;
	localparam logic [STAT_W-1:0] STAT_QUEUE_FULL   = 3'd4;

	// register word index (byte address bits [PADDR_W-1:2])
	localparam logic [PADDR_W-3:0] REG_MAX_LIMIT = 1'd0;

	localparam logic [UNITS_W-1:0] MAX_LIMIT_RST = 32'hFFFF_FFFF;

	typedef struct packed {
		logic               func;
		logic [UNITS_W-1:0] units;
		logic [TAG_W-1:0]   request_tag;
	} in_word_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [STAT_W-1:0]  status;
		logic [TAG_W-1:0]   tag;
		logic [UNITS_W-1:0] granted_units;
		logic [UNITS_W-1:0] units_in_use;
		logic [WAIT_W-1:0]  waiting_count;
		logic               last;
	} out_word_t;

	// shared add/compare unit
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [UNITS_W-1:0] a;
		logic [UNITS_W-1:0] b;
		logic [UNITS_W-1:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [UNITS_W:0] sum;
		logic             fit;
	} alu_rsp_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_LIM,
		ST_ACC_FIT,
		ST_REL_CHK,
		ST_GR_RD,
		ST_GR_FIT
	} state_t;

endpackage

### src/fwac_ram.sv
// -----------------------------------------------------------------------------
// fwac_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module fwac_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/fwac_alu.sv
// -----------------------------------------------------------------------------
// fwac_alu: shared 33-bit add/subtract and fit compare
// ADD: sum = a + b, fit when sum <= c. SUB: sum = a - b, fit when b <= a.
// -----------------------------------------------------------------------------
module fwac_alu (
	input  fwac_pkg::alu_req_t req,
	output fwac_pkg::alu_rsp_t rsp
);
	import fwac_pkg::*;

	logic [UNITS_W:0] add_res;
	logic [UNITS_W:0] sub_res;

	assign add_res = {1'b0, req.a} + {1'b0, req.b};
	assign sub_res = {1'b0, req.a} - {1'b0, req.b};

	always_comb begin
		case (req.op)
			ALU_ADD: begin
				rsp.sum = add_res;
				rsp.fit = (add_res <= {1'b0, req.c});
			end
			ALU_SUB: begin
				rsp.sum = sub_res;
				rsp.fit = !sub_res[UNITS_W];
			end
			default: begin
				rsp.sum = add_res;
				rsp.fit = 1'b0;
			end
		endcase
	end

endmodule

### src/fifo_weighted_admission_control_unit.sv
// -----------------------------------------------------------------------------
// fifo_weighted_admission_control_unit: weighted admission controller
// Tracks units in use under a programmable limit; requests that do not fit
// wait in a FIFO and are granted in head-of-line order on release.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_word  (func, units, request_tag)
//   out       output     out_valid/out_stall out_word (kind .. last)
//   apb       input      psel/penable/pready max_limit at byte address 0
//
// An accept gives its result word from ACC_FIT, or from ACC_LIM when over the
// limit; a release gives its first word from GR_FIT (from REL_CHK on an over
// release) and each further word from GR_FIT again, as the head entry is read
// in GR_RD and then tested in the one shared 33-bit add/compare unit.
// in_stall is high from the accepting edge until the last word is registered;
// the next word can be taken in the cycle after that.
// The waiter queue RAM has no reset; only written entries are read.
// A stalled output word holds the sequencer until the word is taken.
// -----------------------------------------------------------------------------
module fifo_weighted_admission_control_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// item input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  fwac_pkg::in_word_t                in_word,
	// result output
	output logic                              out_valid,
	input  logic                              out_stall,
	output fwac_pkg::out_word_t               out_word,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fwac_pkg::PADDR_W-1:0]      paddr,
	input  logic [fwac_pkg::PDATA_W-1:0]      pwdata,
	output logic [fwac_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	import fwac_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int RAM_W = UNITS_W + TAG_W;

	state_t              state_q, state_d;
	in_word_t            item_q;
	logic [UNITS_W-1:0]  used_q;
	logic [UNITS_W-1:0]  max_limit_q;
	logic [PTR_W-1:0]    head_q, tail_q;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	out_word_t           out_q;

	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;
	logic [RAM_W-1:0]    rd_data;
	logic [UNITS_W-1:0]  rd_units;
	logic [TAG_W-1:0]    rd_tag;

	logic                can_emit;
	logic                emit_req;
	out_word_t           emit_word;
	logic                used_upd;
	logic                enq_req;
	logic                grant_req;
	logic                queue_full;
	logic                cfg_wr;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_MAX_LIMIT);

	always_comb begin
		if (paddr[PADDR_W-1:2] == REG_MAX_LIMIT) begin
			prdata = max_limit_q;
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_limit_q <= MAX_LIMIT_RST;
		end else if (cfg_wr) begin
			max_limit_q <= pwdata;
		end
	end

	// waiter queue storage: {units, tag}, read at head
	fwac_ram #(
		.WIDTH(RAM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (enq_req && can_emit),
		.waddr(tail_q),
		.wdata({item_q.units, item_q.request_tag}),
		.raddr(head_q),
		.rdata(rd_data)
	);

	assign rd_units = rd_data[RAM_W-1:TAG_W];
	assign rd_tag   = rd_data[TAG_W-1:0];

	// shared add/compare unit
	fwac_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign queue_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign can_emit   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);

	// sequencer outputs: unit operands and result word
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = item_q.units;
		alu_req.c  = max_limit_q;
		emit_req   = 1'b0;
		used_upd   = 1'b0;
		enq_req    = 1'b0;
		grant_req  = 1'b0;
		emit_word.kind          = KIND_ACCEPT;
		emit_word.status        = STAT_OK;
		emit_word.tag           = item_q.request_tag;
		emit_word.granted_units = '0;
		emit_word.units_in_use  = used_q;
		emit_word.waiting_count = WAIT_W'(count_q);
		emit_word.last          = 1'b1;
		case (state_q)
			ST_ACC_LIM: begin
				// request alone above the limit
				if (!alu_rsp.fit) begin
					emit_req         = 1'b1;
					emit_word.status = STAT_OVER_LIMIT;
				end
			end
			ST_ACC_FIT: begin
				alu_req.a = used_q;
				emit_req  = 1'b1;
				if (alu_rsp.fit) begin
					used_upd                = 1'b1;
					emit_word.granted_units = item_q.units;
					emit_word.units_in_use  = alu_rsp.sum[UNITS_W-1:0];
				end else if (queue_full) begin
					emit_word.status = STAT_QUEUE_FULL;
				end else begin
					enq_req                 = 1'b1;
					emit_word.status        = STAT_QUEUED;
					emit_word.waiting_count = WAIT_W'(count_q + 1'b1);
				end
			end
			ST_REL_CHK: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = used_q;
				emit_word.kind = KIND_RELEASE;
				if (!alu_rsp.fit) begin
					emit_req         = 1'b1;
					emit_word.status = STAT_OVER_RELEASE;
				end else begin
					used_upd = 1'b1;
				end
			end
			ST_GR_FIT: begin
				alu_req.a = used_q;
				alu_req.b = rd_units;
				emit_req  = 1'b1;
				if ((count_q != '0) && alu_rsp.fit) begin
					grant_req               = 1'b1;
					used_upd                = 1'b1;
					emit_word.kind          = KIND_GRANT;
					emit_word.tag           = rd_tag;
					emit_word.granted_units = rd_units;
					emit_word.units_in_use  = alu_rsp.sum[UNITS_W-1:0];
					emit_word.waiting_count = WAIT_W'(count_q - 1'b1);
					emit_word.last          = 1'b0;
				end else begin
					emit_word.kind = KIND_RELEASE;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_word.func == FUNC_RELEASE) ? ST_REL_CHK : ST_ACC_LIM;
				end
			end
			ST_ACC_LIM: begin
				if (alu_rsp.fit) begin
					state_d = ST_ACC_FIT;
				end else if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_ACC_FIT: begin
				if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_REL_CHK: begin
				if (alu_rsp.fit) begin
					state_d = ST_GR_RD;
				end else if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_GR_RD: begin
				// wait for the registered head entry read
				state_d = ST_GR_FIT;
			end
			ST_GR_FIT: begin
				if (can_emit) begin
					state_d = grant_req ? ST_GR_RD : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (used_upd && (can_emit || !emit_req)) begin
				used_q <= alu_rsp.sum[UNITS_W-1:0];
			end
			if (enq_req && can_emit) begin
				tail_q  <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (grant_req && can_emit) begin
				head_q  <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (emit_req && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_word;
		end
		if (emit_req && can_emit) begin
			out_q <= emit_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### verif/tb_fifo_weighted_admission_control_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_fifo_weighted_admission_control_unit: self-checking bench
// Sends accept and release words under several unit limits. A scoreboard
// tracks units in use and the waiter queue, predicts every result word and
// checks it field by field. The input idles and the output stalls in random bursts.
// -----------------------------------------------------------------------------
module tb_fifo_weighted_admission_control_unit;
	import fwac_pkg::*;

	localparam int WAIT_DEPTH   = QUEUE_DEPTH;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 12;

	// admission scoreboard: own copy of limit, usage and waiter queue
	class admission_checker;
		logic [UNITS_W-1:0] limit;
		logic [UNITS_W-1:0] used;
		logic [UNITS_W-1:0] waiter_units [WAIT_DEPTH];
		logic [TAG_W-1:0]   waiter_tags [WAIT_DEPTH];
		int                 head;
		int                 tail;
		int                 count;
		out_word_t          due_replies [$];
		int                 errors;
		int                 checked;

		function new();
			limit   = MAX_LIMIT_RST;
			used    = '0;
			head    = 0;
			tail    = 0;
			count   = 0;
			errors  = 0;
			checked = 0;
		endfunction

		function void add_reply(logic [KIND_W-1:0] kind, logic [STAT_W-1:0] status,
				logic [TAG_W-1:0] tag, logic [UNITS_W-1:0] granted, logic last);
			out_word_t w;
			w.kind          = kind;
			w.status        = status;
			w.tag           = tag;
			w.granted_units = granted;
			w.units_in_use  = used;
			w.waiting_count = count[WAIT_W-1:0];
			w.last          = last;
			due_replies = {due_replies, w};
		endfunction

		// fit tests run on 33 bits so a lowered limit never wraps
		function bit fits(logic [UNITS_W-1:0] want);
			logic [UNITS_W:0] sum;
			sum = {1'b0, used} + {1'b0, want};
			return sum <= {1'b0, limit};
		endfunction

		function void note_request(in_word_t w);
			int h;
			if (w.func == FUNC_ACCEPT) begin
				if (w.units > limit) begin
					add_reply(KIND_ACCEPT, STAT_OVER_LIMIT, w.request_tag, '0, 1'b1);
				end else if (!fits(w.units)) begin
					if (count >= WAIT_DEPTH) begin
						add_reply(KIND_ACCEPT, STAT_QUEUE_FULL, w.request_tag, '0, 1'b1);
					end else begin
						waiter_units[tail] = w.units;
						waiter_tags[tail]  = w.request_tag;
						tail  = (tail + 1) % WAIT_DEPTH;
						count = count + 1;
						add_reply(KIND_ACCEPT, STAT_QUEUED, w.request_tag, '0, 1'b1);
					end
				end else begin
					used = used + w.units;
					add_reply(KIND_ACCEPT, STAT_OK, w.request_tag, w.units, 1'b1);
				end
			end else if (w.units > used) begin
				add_reply(KIND_RELEASE, STAT_OVER_RELEASE, w.request_tag, '0, 1'b1);
			end else begin
				used = used - w.units;
				// strict head-of-line grants while the head fits
				while (count > 0) begin
					h = head;
					if (!fits(waiter_units[h]))
						break;
					used  = used + waiter_units[h];
					head  = (head + 1) % WAIT_DEPTH;
					count = count - 1;
					add_reply(KIND_GRANT, STAT_OK, waiter_tags[h], waiter_units[h], 1'b0);
				end
				add_reply(KIND_RELEASE, STAT_OK, w.request_tag, '0, 1'b1);
			end
		endfunction

		function void field_check(string name, logic [UNITS_W-1:0] exp_v,
				logic [UNITS_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
					act_v);
				errors++;
			end
		endfunction

		function void check_reply(out_word_t got);
			out_word_t exp_w;
			if (due_replies.size() == 0) begin
				$display("%0t: result word with nothing due, expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			exp_w = due_replies[0];
			due_replies.delete(0);
			field_check("kind", exp_w.kind, got.kind);
			field_check("status", exp_w.status, got.status);
			field_check("tag", exp_w.tag, got.tag);
			field_check("granted_units", exp_w.granted_units, got.granted_units);
			field_check("units_in_use", exp_w.units_in_use, got.units_in_use);
			field_check("waiting_count", exp_w.waiting_count, got.waiting_count);
			field_check("last", exp_w.last, got.last);
			checked++;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_word_t             in_word   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_word_t            out_word;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [PADDR_W-1:0]   paddr     = '0;
	logic [PDATA_W-1:0]   pwdata    = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	admission_checker sb;
	bit               quiet       = 1'b0;
	int               words_sent  = 0;
	int               limit_sets  = 0;
	int unsigned      cycle_count = 0;
	int               stall_run   = 0;
	bit               stall_on    = 1'b0;

	fifo_weighted_admission_control_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// output stall: alternating stall and free bursts, none once quiet
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_run == 0) begin
				stall_on  = !stall_on;
				stall_run = stall_on ? $urandom_range(1, 17) : $urandom_range(1, 40);
			end
			stall_run = stall_run - 1;
			out_stall <= stall_on;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reply(out_word);
	end

	function automatic in_word_t mk_word(logic func, logic [UNITS_W-1:0] units,
			logic [TAG_W-1:0] tag);
		in_word_t w;
		w.func        = func;
		w.units       = units;
		w.request_tag = tag;
		return w;
	endfunction

	// random request: mostly sized to the limit, releases within usage, some noise
	function automatic in_word_t next_request();
		int                 pick;
		longint unsigned    hi;
		logic [UNITS_W-1:0] u;
		logic               f;
		pick = $urandom_range(0, 99);
		hi   = longint'(sb.limit) + longint'(sb.limit) / 4 + 1;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		if (pick < 45) begin
			f = FUNC_ACCEPT;
			if ($urandom_range(0, 1) == 0)
				u = $urandom_range(0, sb.limit / 4);
			else
				u = $urandom_range(0, hi[31:0]);
		end else if (pick < 85) begin
			f = FUNC_RELEASE;
			if ($urandom_range(0, 3) == 0)
				u = sb.used;
			else
				u = $urandom_range(0, sb.used);
		end else if (pick < 93 && sb.used != 32'hFFFF_FFFF) begin
			f = FUNC_RELEASE;
			u = sb.used + 1 + $urandom_range(0, 32'hFFFF_FFFF - sb.used - 1);
		end else begin
			f = FUNC_ACCEPT;
			u = $urandom();
		end
		return mk_word(f, u, TAG_W'($urandom_range(0, 255)));
	endfunction

	// send one input word, with an optional idle burst ahead of it
	task automatic send_word(in_word_t w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(w);
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.due_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr[PADDR_W-1:2] == REG_MAX_LIMIT)
			sb.limit = data;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// program the limit while idle, then read it back
	task automatic set_limit(logic [UNITS_W-1:0] value);
		logic [PDATA_W-1:0] rd;
		wait_drained();
		reg_write({REG_MAX_LIMIT, 2'b00}, value);
		reg_read({REG_MAX_LIMIT, 2'b00}, rd);
		sb.field_check("max_limit readback", value, rd);
		limit_sets++;
	endtask

	task automatic random_phase(logic [UNITS_W-1:0] lim, int n);
		set_limit(lim);
		repeat (n) send_word(next_request());
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: full-scale request, a waiter granted by a release
		send_word(mk_word(FUNC_ACCEPT, 32'd0, 8'h00));
		send_word(mk_word(FUNC_ACCEPT, 32'hFFFF_FFFF, 8'hFF));
		send_word(mk_word(FUNC_ACCEPT, 32'd1, 8'h01));
		send_word(mk_word(FUNC_RELEASE, 32'hFFFF_FFFF, 8'hA5));
		send_word(mk_word(FUNC_RELEASE, 32'd2, 8'h5A));
		send_word(mk_word(FUNC_RELEASE, 32'd1, 8'h3C));

		// small limit: over limit, fill the queue, queue full, admission past waiters
		set_limit(32'd10);
		send_word(mk_word(FUNC_ACCEPT, 32'd11, 8'h10));
		send_word(mk_word(FUNC_ACCEPT, 32'd10, 8'h11));
		for (int i = 0; i < WAIT_DEPTH; i++)
			send_word(mk_word(FUNC_ACCEPT, UNITS_W'((i % 3) + 1), TAG_W'(32'h20 + i)));
		send_word(mk_word(FUNC_ACCEPT, 32'd1, 8'h40));
		send_word(mk_word(FUNC_ACCEPT, 32'd0, 8'h41));
		send_word(mk_word(FUNC_RELEASE, 32'd0, 8'h42));

		// raised limit: a zero release drains every waiter
		set_limit(32'hFFFF_FFFF);
		send_word(mk_word(FUNC_RELEASE, 32'd0, 8'h50));
		send_word(mk_word(FUNC_RELEASE, sb.used, 8'h51));

		// random traffic under several limits, extremes included
		random_phase(32'd64, 30);
		random_phase(32'd0, 10);
		random_phase(32'hFFFF_FFFF, 25);
		random_phase($urandom(), 25);
		random_phase(32'd1000, 25);
		set_limit(32'd200);
		quiet = 1'b1;
		repeat (35) send_word(next_request());

		wait_drained();
		repeat (20) @(posedge clk);
		$display("summary: %0d input words, %0d result words checked", words_sent,
			sb.checked);
		$display("summary: %0d limit settings, queue fill, drain and error cases run",
			limit_sets);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
src/fwac_pkg.sv
src/fwac_ram.sv
src/fwac_alu.sv
src/fifo_weighted_admission_control_unit.sv
verif/tb_fifo_weighted_admission_control_unit.sv
